// ===== hw/rtl/lkvc_pkg.sv =====
// Shared constants for the LRU key/value cache.
`default_nettype none

package lkvc_pkg;

   // Number of cache entries.
   localparam int ENTRIES = 16;

   // Index, rank and occupancy widths follow from the entry count.
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AGE_W = IDX_W;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Field widths of the channels.
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Width in which occupancy and capacity are compared.
   localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Command codes.
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   // Value returned by a get that misses.
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

endpackage : lkvc_pkg

`default_nettype wire

// ===== hw/rtl/lkvc_req_if.sv =====
// Request channel of the LRU key/value cache.
`default_nettype none

interface lkvc_req_if;
   import lkvc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    command;
   logic signed [KEY_W-1:0] lookup_key;
   logic signed [VAL_W-1:0] store_value;

   modport source (output valid, output command, output lookup_key, output store_value,
                   input ready);
   modport sink   (input valid, input command, input lookup_key, input store_value,
                   output ready);
endinterface : lkvc_req_if

`default_nettype wire

// ===== hw/rtl/lkvc_rsp_if.sv =====
// Response channel of the LRU key/value cache.
`default_nettype none

interface lkvc_rsp_if;
   import lkvc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic signed [VAL_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface : lkvc_rsp_if

`default_nettype wire

// ===== hw/rtl/lkvc_csr_if.sv =====
// Capacity register write channel of the LRU key/value cache.
`default_nettype none

interface lkvc_csr_if;
   import lkvc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] capacity;

   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface : lkvc_csr_if

`default_nettype wire

// ===== hw/rtl/lkvc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : lkvc_ram

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key/value cache.
//
// The cache holds up to ENTRIES key/value pairs. Each item on the request channel
// (req_ch) is a get or a set of a 32-bit key. A get returns one item on the response
// channel (rsp_ch): the stored value with hit set, or all ones with hit clear. A set
// returns nothing. Hits make the entry most recent; a set that misses fills the lowest
// free entry while occupancy is below the capacity register, and otherwise replaces the
// least recent entry.
// The capacity register is written through csr_ch while the cache is idle; each write
// empties the whole cache. Reset empties the cache and sets the capacity to 16.
// Sequencing: one compare unit walks the key RAM one entry per cycle, so every request
// scans all ENTRIES entries. A set is finished in the decide state that follows the
// scan. A get goes from the decide state through a value RAM read (on a hit only) to
// the response state, which loads the output register. One request is in flight at a
// time; req_ch.ready is high only while the cache is idle.
// The response sits in an output register. If the receiver stalls, the cache still
// accepts and completes further sets and finishes the next get's scan, then waits
// until the output register is free before delivering that get's response.
`default_nettype none

module lru_key_value_cache_top (
   input  wire logic   clock,
   input  wire logic   reset,
   lkvc_req_if.sink    req_ch,
   lkvc_rsp_if.source  rsp_ch,
   lkvc_csr_if.sink    csr_ch
);
   import lkvc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_READ   = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   // Sequencer and request registers.
   state_type        state_ff, state_in;
   logic             cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;

   // Scan counter and the index of the key RAM data being compared.
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   // Results gathered during the scan.
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic [AGE_W-1:0] found_age_ff, found_age_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             old_ff, old_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [AGE_W-1:0] old_age_ff, old_age_in;

   // Per-entry valid bits and recency ranks, plus occupancy and capacity.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [AGE_W-1:0]   age_ff [ENTRIES];
   logic [AGE_W-1:0]   age_in [ENTRIES];
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;

   // Pending response and the output register.
   logic             res_hit_ff, res_hit_in;
   logic [VAL_W-1:0] res_value_ff, res_value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   // RAM ports.
   logic             key_wr_en, key_rd_en;
   logic [IDX_W-1:0] key_wr_addr, key_rd_addr;
   logic [KEY_W-1:0] key_rdata;
   logic             val_wr_en, val_rd_en;
   logic [IDX_W-1:0] val_wr_addr, val_rd_addr;
   logic [VAL_W-1:0] val_rdata;

   // Rank update controls.
   logic             prom_en;
   logic             prom_all;
   logic             fill_en;
   logic [IDX_W-1:0] prom_idx;
   logic [AGE_W-1:0] prom_limit;

   // Combinational helpers.
   logic             req_accept;
   logic             csr_write;
   logic             cmp_valid;
   logic [AGE_W-1:0] cmp_age;
   logic             key_match;
   logic [CAP_W-1:0] cap_floor;
   logic             below_cap;

   lkvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rdata)
   );

   lkvc_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_ff),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = rsp_hit_ff;
   assign rsp_ch.read_value = rsp_value_ff;

   // The shared compare unit looks at one entry per cycle.
   assign cmp_valid = valid_ff[cmp_idx_ff];
   assign cmp_age   = age_ff[cmp_idx_ff];
   assign key_match = cmp_valid && (key_rdata == key_ff);

   // A capacity of zero acts as one; anything above ENTRIES acts as ENTRIES.
   assign cap_floor = (cap_ff == '0) ? CAP_W'(1) : cap_ff;
   assign below_cap = (CMP_W'(occ_ff) < CMP_W'(cap_floor)) &&
                      (CMP_W'(occ_ff) < CMP_W'(ENTRIES));

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_age_in = found_age_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_in       = old_ff;
      old_idx_in   = old_idx_ff;
      old_age_in   = old_age_ff;
      occ_in       = occ_ff;
      cap_in       = cap_ff;
      res_hit_in   = res_hit_ff;
      res_value_in = res_value_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_ch.ready) ? 1'b0 : rsp_valid_ff;

      key_wr_en   = 1'b0;
      key_wr_addr = '0;
      key_rd_en   = 1'b0;
      key_rd_addr = '0;
      val_wr_en   = 1'b0;
      val_wr_addr = '0;
      val_rd_en   = 1'b0;
      val_rd_addr = '0;

      prom_en    = 1'b0;
      prom_all   = 1'b0;
      fill_en    = 1'b0;
      prom_idx   = '0;
      prom_limit = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in      = req_ch.command;
               key_in      = req_ch.lookup_key;
               val_in      = req_ch.store_value;
               key_rd_en   = 1'b1;
               key_rd_addr = '0;
               scan_in     = CNT_W'(1);
               cmp_idx_in  = '0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               old_in      = 1'b0;
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            if (!found_ff && key_match) begin
               found_in     = 1'b1;
               found_idx_in = cmp_idx_ff;
               found_age_in = cmp_age;
            end
            if (!free_ff && !cmp_valid) begin
               free_in     = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
            // Oldest valid entry; the lowest index wins a tie.
            if (cmp_valid && (!old_ff || (cmp_age > old_age_ff))) begin
               old_in     = 1'b1;
               old_idx_in = cmp_idx_ff;
               old_age_in = cmp_age;
            end
            if (scan_ff < CNT_W'(ENTRIES)) begin
               key_rd_en   = 1'b1;
               key_rd_addr = scan_ff[IDX_W-1:0];
               cmp_idx_in  = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end
            if (cmp_idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            if (cmd_ff == CMD_GET) begin
               if (found_ff) begin
                  val_rd_en   = 1'b1;
                  val_rd_addr = found_idx_ff;
                  prom_en     = 1'b1;
                  prom_idx    = found_idx_ff;
                  prom_limit  = found_age_ff;
                  state_in    = S_READ;
               end else begin
                  res_hit_in   = 1'b0;
                  res_value_in = MISS_VALUE;
                  state_in     = S_RESP;
               end
            end else begin
               priority if (found_ff) begin
                  val_wr_en   = 1'b1;
                  val_wr_addr = found_idx_ff;
                  prom_en     = 1'b1;
                  prom_idx    = found_idx_ff;
                  prom_limit  = found_age_ff;
               end else if (below_cap && free_ff) begin
                  key_wr_en   = 1'b1;
                  key_wr_addr = free_idx_ff;
                  val_wr_en   = 1'b1;
                  val_wr_addr = free_idx_ff;
                  fill_en     = 1'b1;
                  prom_en     = 1'b1;
                  prom_all    = 1'b1;
                  prom_idx    = free_idx_ff;
                  occ_in      = occ_ff + CNT_W'(1);
               end else if (old_ff) begin
                  key_wr_en   = 1'b1;
                  key_wr_addr = old_idx_ff;
                  val_wr_en   = 1'b1;
                  val_wr_addr = old_idx_ff;
                  prom_en     = 1'b1;
                  prom_all    = 1'b1;
                  prom_idx    = old_idx_ff;
               end else begin
                  prom_en = 1'b0;
               end
               state_in = S_IDLE;
            end
         end

         S_READ: begin
            res_hit_in   = 1'b1;
            res_value_in = val_rdata;
            state_in     = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_value_in = res_value_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write) begin
         cap_in = csr_ch.capacity;
         occ_in = '0;
      end
   end

   // Rank update, one lane per entry. Entries more recent than the limit (all valid
   // entries when prom_all is set) age by one, the promoted entry becomes rank zero.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         age_in[i]   = age_ff[i];
         if (csr_write) begin
            valid_in[i] = 1'b0;
            age_in[i]   = '0;
         end else if (prom_en) begin
            if (IDX_W'(i) == prom_idx) begin
               age_in[i] = '0;
               if (fill_en) begin
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && (prom_all || (age_ff[i] < prom_limit))) begin
               age_in[i] = age_ff[i] + AGE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         age_ff       <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      found_age_ff <= found_age_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      old_ff       <= old_in;
      old_idx_ff   <= old_idx_in;
      old_age_ff   <= old_age_in;
      res_hit_ff   <= res_hit_in;
      res_value_ff <= res_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   // An accepted request always starts a scan.
   a_req_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_SCAN))
      else $error("accepted request did not start a scan");

   // A set finishes without producing a response.
   a_set_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && cmd_ff == CMD_SET) |=> (state_ff == S_IDLE))
      else $error("set did not return to idle");

   // Occupancy always equals the number of valid entries.
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy count disagrees with valid bits");

   // A new response only appears from the response state.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("response appeared outside the response state");

endmodule : lru_key_value_cache_top

`default_nettype wire

// ===== dv/lkvc_tb_pkg.sv =====
// Shadow copy of the LRU key/value cache, used to predict and check read results.
`timescale 1ns / 1ps

package lkvc_tb_pkg;
   import lkvc_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] value;
   } read_result_type;

   class cache_mirror;
      logic [CAP_W-1:0] capacity;
      bit               in_use [ENTRIES];
      logic [KEY_W-1:0] keys   [ENTRIES];
      logic [VAL_W-1:0] values [ENTRIES];
      int unsigned      rank   [ENTRIES];
      int unsigned      occupancy;
      read_result_type  pending_reads [$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
         write_capacity(CAP_RESET);
      endfunction

      // A capacity write empties the whole store.
      function void write_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
         foreach (in_use[i]) begin
            in_use[i] = 1'b0;
            rank[i]   = 0;
         end
         occupancy = 0;
      endfunction

      // Zero behaves as one, anything above the table size as the table size.
      function int unsigned usable_entries();
         if (capacity == 0) return 1;
         if (capacity > ENTRIES) return ENTRIES;
         return capacity;
      endfunction

      function int lookup(logic [KEY_W-1:0] key);
         foreach (in_use[i])
            if (in_use[i] && keys[i] == key) return i;
         return -1;
      endfunction

      // Entries more recent than the limit move back one rank; the slot becomes newest.
      function void make_recent(int slot, int unsigned limit);
         foreach (rank[i])
            if (i != slot && in_use[i] && rank[i] < limit) rank[i]++;
         rank[slot] = 0;
      endfunction

      function void note_request(logic command, logic [KEY_W-1:0] key,
                                 logic [VAL_W-1:0] value);
         int              slot;
         read_result_type result;
         slot = lookup(key);
         if (command == CMD_GET) begin
            if (slot >= 0) begin
               result.hit   = 1'b1;
               result.value = values[slot];
               make_recent(slot, rank[slot]);
            end else begin
               result.hit   = 1'b0;
               result.value = MISS_VALUE;
            end
            pending_reads.push_back(result);
            return;
         end
         if (slot >= 0) begin
            values[slot] = value;
            make_recent(slot, rank[slot]);
            return;
         end
         if (occupancy < usable_entries()) begin
            for (int i = 0; i < ENTRIES && slot < 0; i++)
               if (!in_use[i]) slot = i;
         end
         if (slot >= 0) begin
            occupancy++;
         end else begin
            // Victim is the oldest entry, lowest index on a tie.
            for (int i = 0; i < ENTRIES; i++)
               if (in_use[i] && (slot < 0 || rank[i] > rank[slot])) slot = i;
            if (slot < 0) return;
         end
         in_use[slot] = 1'b1;
         keys[slot]   = key;
         values[slot] = value;
         make_recent(slot, 32'hFFFF_FFFF);
      endfunction

      function void check_response(logic hit, logic [VAL_W-1:0] value);
         read_result_type want;
         if (pending_reads.size() == 0) begin
            $error("unexpected read result: hit %0b read_value %h", hit, value);
            mismatches++;
            return;
         end
         want = pending_reads.pop_front();
         if (hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, hit);
            mismatches++;
         end
         if (value !== want.value) begin
            $error("read_value: expected %h, actual %h", want.value, value);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_reads.size();
      endfunction
   endclass

endpackage : lkvc_tb_pkg

// ===== dv/tb_top.sv =====
// Self-checking testbench for the fully associative LRU key/value cache.
`timescale 1ns / 1ps

module tb_top;
   import lkvc_pkg::*;
   import lkvc_tb_pkg::*;

   // A whole scan plus some margin; used to let a trailing set finish.
   localparam int SETTLE_CYCLES = ENTRIES + 8;
   // The one deliberate long stall on the response side.
   localparam int LONG_HOLD     = 400;
   // Cycles without any handshake before the run is declared hung. The longest
   // correct quiet stretch comes with the long hold and is far below this.
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 85;

   logic clock = 1'b0;
   logic reset;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   lkvc_req_if req_ch ();
   lkvc_rsp_if rsp_ch ();
   lkvc_csr_if csr_ch ();

   lru_key_value_cache_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cache_mirror mirror = new();

   // Set by the stimulus to ask the response side for one long stall; the
   // response process clears it when the stall is over.
   bit hold_output = 1'b0;
   // In the final phase neither side inserts idle cycles.
   bit quiet_tail  = 1'b0;
   int unsigned idle_cycles = 0;

   // All handshakes are observed in one place, in a fixed order, so that a
   // request and a response that complete at the same edge are always booked
   // the same way. Values are read before the edge's nonblocking updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            mirror.check_response(rsp_ch.hit, rsp_ch.read_value);
         if (csr_ch.valid && csr_ch.ready)
            mirror.write_capacity(csr_ch.capacity);
         if (req_ch.valid && req_ch.ready)
            mirror.note_request(req_ch.command, req_ch.lookup_key, req_ch.store_value);
      end
   end

   // Watchdog: the run is hung if no channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Response side: ready comes in random stretches, with random stalls, one long
   // hold on request, and no stalls at all in the final phase. Every branch makes
   // one assignment and then waits on the clock before the next.
   initial begin : response_sink
      forever begin
         if (hold_output) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_output = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Offers one request item and returns at the edge where it is taken.
   // An optional idle burst comes first; valid is never dropped and raised
   // again within one time step.
   task automatic send_item(input logic command, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= command;
      req_ch.lookup_key  <= key;
      req_ch.store_value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // The capacity is only written while the cache is idle: every read result
   // has come back, and a trailing set has had a full scan to finish, since a
   // set leaves no result to wait for. The task first waits on the clock so that the last
   // accepted request has been booked by the monitor.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid    <= 1'b1;
      csr_ch.capacity <= cap;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Random traffic over a key pool a little larger than the usable capacity,
   // so that hits, updates, fills and evictions all happen often. One key in
   // ten is fully random and almost always misses.
   task automatic run_phase(input logic [CAP_W-1:0] cap, input int count,
                            input bit with_hold);
      logic [KEY_W-1:0] pool [];
      int               span;
      logic             command;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      write_capacity(cap);
      span = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
      pool = new[span + $urandom_range(1, span + 3)];
      foreach (pool[i]) pool[i] = $urandom;
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7FFF_FFFF;
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == count / 4) hold_output = 1'b1;
         command = ($urandom_range(0, 99) < 55) ? CMD_GET : CMD_SET;
         key     = ($urandom_range(0, 9) == 0) ? $urandom
                                               : pool[$urandom_range(0, pool.size() - 1)];
         case ($urandom_range(0, 9))
            0: begin
               value = '1;
            end
            1: begin
               value = 32'h8000_0000;
            end
            default: begin
               value = $urandom;
            end
         endcase
         send_item(command, key, value);
      end
   endtask

   initial begin : stimulus
      // Every input is known from time zero.
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_GET;
      req_ch.lookup_key  <= '0;
      req_ch.store_value <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.capacity    <= CAP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity: a get on the empty cache, the extreme keys and values,
      // a stored value of all ones that must still report a hit, two keys that
      // differ only in the low bit, and an update of an existing key.
      send_item(CMD_GET, 32'h0000_0000, $urandom);
      send_item(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(CMD_SET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(CMD_SET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(CMD_GET, 32'h8000_0000, $urandom);
      send_item(CMD_GET, 32'h7FFF_FFFF, $urandom);
      send_item(CMD_GET, 32'h0000_0000, $urandom);
      send_item(CMD_GET, 32'hFFFF_FFFF, $urandom);
      send_item(CMD_GET, 32'h8000_0001, $urandom);
      send_item(CMD_SET, 32'h0000_0000, 32'h0000_0005);
      send_item(CMD_GET, 32'h0000_0000, $urandom);

      // Capacity of two: the write empties the cache, then a get refreshes the
      // first key so that the third set evicts the second one.
      write_capacity(5'd2);
      send_item(CMD_GET, 32'h8000_0000, $urandom);
      send_item(CMD_SET, 32'd10, 32'd100);
      send_item(CMD_SET, 32'd20, 32'd200);
      send_item(CMD_GET, 32'd10, $urandom);
      send_item(CMD_SET, 32'd30, 32'd300);
      send_item(CMD_GET, 32'd20, $urandom);
      send_item(CMD_GET, 32'd10, $urandom);
      send_item(CMD_GET, 32'd30, $urandom);

      // A capacity of zero behaves as one: the second set evicts the first.
      write_capacity(5'd0);
      send_item(CMD_SET, 32'd1, 32'd11);
      send_item(CMD_SET, 32'd2, 32'd22);
      send_item(CMD_GET, 32'd1, $urandom);
      send_item(CMD_GET, 32'd2, $urandom);

      // Random phases over the capacity extremes and a few values between,
      // including settings above the table size. The first phase carries the
      // long response stall that backs the cache up into its request side.
      run_phase(5'd16, PHASE_ITEMS, 1'b1);
      run_phase(5'd1,  PHASE_ITEMS, 1'b0);
      run_phase(5'd31, PHASE_ITEMS, 1'b0);
      run_phase(5'd3,  PHASE_ITEMS, 1'b0);
      run_phase(5'd0,  PHASE_ITEMS, 1'b0);
      run_phase(5'($urandom_range(2, 15)), PHASE_ITEMS, 1'b0);
      run_phase(5'd17, PHASE_ITEMS, 1'b0);
      quiet_tail = 1'b1;
      run_phase(5'd8,  PHASE_ITEMS, 1'b0);

      // Drain: wait for every read result, then watch a while for strays.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule : tb_top
